/* rtl/core/msc_pkg.sv */
// Shared types, constants and the ALU function for the MIPS-subset core.
// No dependencies; imported by every module under rtl/core.
package msc_pkg;

    // Data memory geometry: four byte lanes, big-endian words
    localparam int DATA_MEM_BYTES = 65536;
    localparam int DM_AW          = $clog2(DATA_MEM_BYTES);
    localparam int NUM_BANKS      = 4;
    localparam int DM_RW          = DM_AW - 2;
    localparam int DM_ROWS        = DATA_MEM_BYTES / NUM_BANKS;

    // Register file geometry
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    // Major opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_JUMP  = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // ALU operation codes
    localparam logic [2:0] ALU_ADD = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_OR  = 3'd5;
    localparam logic [2:0] ALU_NOR = 3'd7;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // One result word
    typedef struct packed {
        logic [31:0]      next_pc;
        logic             halted;
        logic             reg_written;
        logic [RF_AW-1:0] reg_index;
        logic [31:0]      reg_value;
        logic [7:0]       read_byte;
    } t_result;

    // Register file write port
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] idx;
        logic [31:0]      data;
    } t_rf_wr;

    // Data memory request, one row and byte per lane
    typedef struct packed {
        logic                              rd_en;
        logic [NUM_BANKS-1:0]              wr_en;
        logic [NUM_BANKS-1:0][DM_RW-1:0]   row;
        logic [NUM_BANKS-1:0][7:0]         wdata;
    } t_dm_req;

    function automatic logic [31:0] msc_alu(input logic [2:0] op, input logic [31:0] a,
                                            input logic [31:0] b);
        case (op)
            ALU_ADD: return a + b;
            ALU_SUB: return a - b;
            ALU_AND: return a & b;
            ALU_OR:  return a | b;
            ALU_NOR: return ~(a | b);
            default: return 32'd0;
        endcase
    endfunction

endpackage

/* rtl/core/msc_rf.sv */
// Register file: 32 x 32 synchronous RAM, two registered read ports, one write port.
// Per-entry valid bits make unwritten registers (and register zero) read as zero.
// Depends on msc_pkg.
module msc_rf
    import msc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [RF_AW-1:0] i_rd_idx_a,
    input  logic [RF_AW-1:0] i_rd_idx_b,
    input  t_rf_wr           i_wr,
    output logic [31:0]      o_rd_data_a,
    output logic [31:0]      o_rd_data_b
);

    logic [31:0]         mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] r_valid;
    logic [31:0]         r_rd_a;
    logic [31:0]         r_rd_b;
    logic                r_va;
    logic                r_vb;

    // Write the array and read both ports, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= mem[i_rd_idx_a];
            r_rd_b <= mem[i_rd_idx_b];
            r_va   <= r_valid[i_rd_idx_a];
            r_vb   <= r_valid[i_rd_idx_b];
        end
    end

    // Clear valid bits on reset, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    assign o_rd_data_a = r_va ? r_rd_a : 32'd0;
    assign o_rd_data_b = r_vb ? r_rd_b : 32'd0;

endmodule

/* rtl/core/msc_dmem.sv */
// Data memory: four byte-lane synchronous RAMs, one read and one write per lane per cycle.
// Byte address a sits in lane a mod 4, row a / 4. Depends on msc_pkg.
module msc_dmem
    import msc_pkg::*;
(
    input  logic                      i_clk,
    input  t_dm_req                   i_req,
    output logic [NUM_BANKS-1:0][7:0] o_rd_data
);

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [7:0] mem [DM_ROWS];
        logic [7:0] r_rd;

        // Write and read one row of this lane
        always_ff @(posedge i_clk) begin
            if (i_req.wr_en[g]) begin
                mem[i_req.row[g]] <= i_req.wdata[g];
            end
            if (i_req.rd_en) begin
                r_rd <= mem[i_req.row[g]];
            end
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

/* rtl/core/msc_outq.sv */
// Two-entry output buffer: head drives the result port, tail absorbs one word
// while the head is stalled. Depends on msc_pkg.
module msc_outq
    import msc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_hv;
    logic    r_tv;
    t_result r_head;
    t_result r_tail;
    logic    n_hv;
    logic    n_tv;
    t_result n_head;
    t_result n_tail;
    logic    pop;

    assign pop = r_hv && !i_stall;

    // Drop the taken head, then place the new word
    always_comb begin
        n_hv   = r_hv;
        n_tv   = r_tv;
        n_head = r_head;
        n_tail = r_tail;
        if (pop) begin
            if (r_tv) begin
                n_head = r_tail;
                n_tv   = 1'b0;
            end else begin
                n_hv = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_hv) begin
                n_head = i_data;
                n_hv   = 1'b1;
            end else begin
                n_tail = i_data;
                n_tv   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_tv <= 1'b0;
        end else begin
            r_hv <= n_hv;
            r_tv <= n_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_valid = r_hv;
    assign o_data  = r_head;
    assign o_full  = r_tv;

endmodule

/* rtl/core/mips_subset_single_cycle_core.sv */
// Top level of the MIPS-subset core: front end, execute stage, write-back stage.
// Uses msc_pkg, msc_rf, msc_dmem and msc_outq.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | i_valid / o_stall    | i_cmd, i_instruction, i_mem_address, i_mem_byte
//   output   | o_valid / i_stall    | o_next_pc, o_halted, o_reg_written,
//            |                      | o_reg_index, o_reg_value, o_read_byte
//
// One word is accepted per cycle while o_stall is low; its result passes the execute
// and write-back stages and the output buffer. Register file read (accept), data
// memory access (execute) and load data return (write-back) use synchronous RAMs.
// Reset clears PC, halt flag, pipeline valids and register valid bits at once;
// data memory is not cleared, so the core accepts words right after reset.
// o_stall rises only when the output buffer holds two words; the pipeline then holds.
module mips_subset_single_cycle_core
    import msc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_cmd,
    input  logic [31:0]      i_instruction,
    input  logic [15:0]      i_mem_address,
    input  logic [7:0]       i_mem_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_next_pc,
    output logic             o_halted,
    output logic             o_reg_written,
    output logic [RF_AW-1:0] o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic [7:0]       o_read_byte
);

    logic adv;
    logic accept;
    logic ob_full;

    // Architectural state
    logic [31:0] r_pc;
    logic        r_halt;

    // Execute stage
    logic             r_s1_v;
    t_cmd             r_s1_cmd;
    logic [31:0]      r_s1_ins;
    logic [DM_AW-1:0] r_s1_addr;
    logic [7:0]       r_s1_mbyte;

    // Write-back stage
    logic             r_s2_v;
    logic             r_s2_lw;
    logic             r_s2_rb;
    logic             r_s2_wr;
    logic [RF_AW-1:0] r_s2_dest;
    logic [31:0]      r_s2_res;
    logic [1:0]       r_s2_lo;
    logic [31:0]      r_s2_pc;
    logic             r_s2_halt;

    // Register write done at the last advance
    logic             r_lw_en;
    logic [RF_AW-1:0] r_lw_idx;
    logic [31:0]      r_lw_val;

    logic [31:0]      rf_a;
    logic [31:0]      rf_b;
    t_rf_wr           rf_wr;
    t_dm_req          dm_req;
    logic [NUM_BANKS-1:0][7:0] dm_rd;
    t_result          res_word;
    t_result          ob_data;

    // Execute-stage decode
    logic [5:0]       op;
    logic [RF_AW-1:0] rs;
    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
    logic [31:0]      simm;
    logic [31:0]      a_val;
    logic [31:0]      b_val;
    logic             is_exec;
    logic             is_halt;
    logic             run;
    logic             is_r;
    logic             is_j;
    logic             is_beq;
    logic             is_lw;
    logic             is_sw;
    logic [2:0]       aluop;
    logic [31:0]      alu_res;
    logic [31:0]      pc4;
    logic [31:0]      next_pc;
    logic [RF_AW-1:0] dest;
    logic             s1_wr;
    logic [31:0]      n_pc;
    logic             n_halt;
    logic [DM_AW-1:0] s1_maddr;
    logic             s1_go;

    // Write-back values
    logic [31:0]      lw_word;
    logic [7:0]       rd_byte;
    logic [31:0]      s2_val;

    assign adv     = !ob_full;
    assign accept  = i_valid && adv;
    assign o_stall = !adv;
    assign s1_go   = adv && r_s1_v;

    // Read both source registers as the word is accepted
    msc_rf u_rf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_idx_a  (i_instruction[25:21]),
        .i_rd_idx_b  (i_instruction[20:16]),
        .i_wr        (rf_wr),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    msc_dmem u_dmem (
        .i_clk     (i_clk),
        .i_req     (dm_req),
        .o_rd_data (dm_rd)
    );

    // Decode fields
    assign op   = r_s1_ins[31:26];
    assign rs   = r_s1_ins[25:21];
    assign rt   = r_s1_ins[20:16];
    assign rd   = r_s1_ins[15:11];
    assign simm = {{16{r_s1_ins[15]}}, r_s1_ins[15:0]};

    // Forward from write-back, then from the write done at the read edge
    always_comb begin
        if (r_s2_v && r_s2_wr && r_s2_dest == rs) begin
            a_val = s2_val;
        end else if (r_lw_en && r_lw_idx == rs) begin
            a_val = r_lw_val;
        end else begin
            a_val = rf_a;
        end
        if (r_s2_v && r_s2_wr && r_s2_dest == rt) begin
            b_val = s2_val;
        end else if (r_lw_en && r_lw_idx == rt) begin
            b_val = r_lw_val;
        end else begin
            b_val = rf_b;
        end
    end

    // Execute: ALU, branch and jump target, state update
    always_comb begin
        is_exec = (r_s1_cmd == CMD_EXEC) && !r_halt;
        is_halt = is_exec && (r_s1_ins == HALT_WORD);
        run     = is_exec && !is_halt;
        is_r    = (op == OP_RTYPE);
        is_j    = (op == OP_JUMP);
        is_beq  = (op == OP_BEQ);
        is_lw   = (op == OP_LW);
        is_sw   = (op == OP_SW);
        if (is_lw || is_sw) begin
            aluop = ALU_ADD;
        end else if (is_r) begin
            aluop = r_s1_ins[2:0];
        end else begin
            aluop = op[2:0];
        end
        alu_res = msc_alu(aluop, a_val, is_r ? b_val : simm);
        pc4     = r_pc + 32'd4;
        next_pc = pc4;
        if (is_j) begin
            next_pc = {pc4[31:28], r_s1_ins[25:0], 2'b00};
        end else if (is_beq && a_val == b_val) begin
            next_pc = pc4 + {simm[29:0], 2'b00};
        end
        dest     = is_r ? rd : rt;
        s1_wr    = run && !is_j && !is_sw && !is_beq && (dest != '0);
        n_pc     = run ? next_pc : r_pc;
        n_halt   = r_halt || is_halt;
        s1_maddr = (r_s1_cmd == CMD_EXEC) ? alu_res[DM_AW-1:0] : r_s1_addr;
    end

    // Build the lane requests for word and byte accesses
    always_comb begin
        logic [1:0] k;
        dm_req       = '0;
        dm_req.rd_en = s1_go && ((run && is_lw) || r_s1_cmd == CMD_READ);
        for (int b = 0; b < NUM_BANKS; b++) begin
            k = 2'(b) - s1_maddr[1:0];
            dm_req.row[b] = s1_maddr[DM_AW-1:2] + DM_RW'(2'(b) < s1_maddr[1:0]);
            if (r_s1_cmd == CMD_EXEC) begin
                dm_req.wdata[b] = b_val[(5'd24 - {k, 3'b000}) +: 8];
            end else begin
                dm_req.wdata[b] = r_s1_mbyte;
            end
            dm_req.wr_en[b] = s1_go && ((run && is_sw) ||
                              (r_s1_cmd == CMD_WRITE && s1_maddr[1:0] == 2'(b)));
        end
    end

    // Assemble the loaded word and the read byte
    always_comb begin
        lw_word = '0;
        for (int k2 = 0; k2 < NUM_BANKS; k2++) begin
            lw_word[8*(3-k2) +: 8] = dm_rd[r_s2_lo + 2'(k2)];
        end
        rd_byte = dm_rd[r_s2_lo];
        s2_val  = r_s2_lw ? lw_word : r_s2_res;
    end

    // Write back and form the result word
    always_comb begin
        rf_wr.en             = adv && r_s2_v && r_s2_wr;
        rf_wr.idx            = r_s2_dest;
        rf_wr.data           = s2_val;
        res_word.next_pc     = r_s2_pc;
        res_word.halted      = r_s2_halt;
        res_word.reg_written = r_s2_wr;
        res_word.reg_index   = r_s2_wr ? r_s2_dest : '0;
        res_word.reg_value   = r_s2_wr ? s2_val : 32'd0;
        res_word.read_byte   = r_s2_rb ? rd_byte : 8'd0;
    end

    msc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv && r_s2_v),
        .i_data  (res_word),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (ob_data),
        .o_full  (ob_full)
    );

    // Control state: advance on every cycle the buffer has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= 32'd0;
            r_halt  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_lw_en <= 1'b0;
        end else if (adv) begin
            r_s1_v  <= accept;
            r_s2_v  <= r_s1_v;
            r_lw_en <= r_s2_v && r_s2_wr;
            if (r_s1_v) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
            end
        end
    end

    // Payload: load the input word, pass execute results on
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= t_cmd'(i_cmd);
            r_s1_ins   <= i_instruction;
            r_s1_addr  <= i_mem_address[DM_AW-1:0];
            r_s1_mbyte <= i_mem_byte;
        end
        if (adv) begin
            r_lw_idx  <= r_s2_dest;
            r_lw_val  <= s2_val;
            r_s2_lw   <= run && is_lw;
            r_s2_rb   <= (r_s1_cmd == CMD_READ);
            r_s2_wr   <= s1_wr;
            r_s2_dest <= dest;
            r_s2_res  <= alu_res;
            r_s2_lo   <= s1_maddr[1:0];
            r_s2_pc   <= n_pc;
            r_s2_halt <= n_halt;
        end
    end

    assign o_next_pc     = ob_data.next_pc;
    assign o_halted      = ob_data.halted;
    assign o_reg_written = ob_data.reg_written;
    assign o_reg_index   = ob_data.reg_index;
    assign o_reg_value   = ob_data.reg_value;
    assign o_read_byte   = ob_data.read_byte;

`ifndef ASSERT_OFF
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_no_write_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> (rf_wr.idx != '0))
        else $error("write to register zero");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_v)
        else $error("accepted word lost before execute stage");

    a_freeze_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ob_full |-> (!dm_req.rd_en && dm_req.wr_en == '0 && !rf_wr.en))
        else $error("memory access while pipeline holds");
`endif

endmodule

/* test/tb_mips_subset_single_cycle_core.sv */
// Self-checking testbench for mips_subset_single_cycle_core: directed and random words
// with random idling on both channels, checked against an in-bench architectural predictor.
// Depends on msc_pkg and the core RTL only.
module tb_mips_subset_single_cycle_core;
    import msc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int WINDOW_BYTES   = 64;

    // Opcodes and ALU codes used by the stimulus beyond those in the package
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [2:0] ALU_UNDEF = 3'd6;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_stall = 1'b0;
    logic [1:0]       i_cmd = CMD_NONE;
    logic [31:0]      i_instruction = '0;
    logic [15:0]      i_mem_address = '0;
    logic [7:0]       i_mem_byte = '0;
    logic             o_stall;
    logic             o_valid;
    logic [31:0]      o_next_pc;
    logic             o_halted;
    logic             o_reg_written;
    logic [RF_AW-1:0] o_reg_index;
    logic [31:0]      o_reg_value;
    logic [7:0]       o_read_byte;

    // Architectural state of the predictor
    logic [31:0] arch_pc = '0;
    logic        arch_halted = 1'b0;
    logic [31:0] arch_regs [RF_DEPTH];
    logic [7:0]  arch_mem [DATA_MEM_BYTES];
    bit          mem_loaded [DATA_MEM_BYTES];

    t_result     pending_retires [$];
    logic [15:0] stored_words [$];
    logic [15:0] window_base;
    bit          idle_en = 1'b0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned stuck_cycles = 0;

    mips_subset_single_cycle_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_instruction (i_instruction),
        .i_mem_address (i_mem_address),
        .i_mem_byte    (i_mem_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_next_pc     (o_next_pc),
        .o_halted      (o_halted),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_read_byte   (o_read_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int r = 0; r < RF_DEPTH; r++) arch_regs[r] = '0;
    end

    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [2:0] aop);
        return {OP_RTYPE, rs, rt, rd, 5'd0, 3'b100, aop};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Retire one word on the architectural state and return the result it produces
    function automatic t_result predict_retire(t_cmd c, logic [31:0] ins,
                                               logic [15:0] addr, logic [7:0] data);
        t_result          r;
        logic [5:0]       op;
        logic [4:0]       rs, rt, dest;
        logic [31:0]      x, y, b, simm, pc4, nxt, sum, val;
        logic [2:0]       aop;
        logic [DM_AW-1:0] loc;
        int               k;
        r    = '0;
        op   = ins[31:26];
        rs   = ins[25:21];
        rt   = ins[20:16];
        dest = (op == OP_RTYPE) ? ins[15:11] : rt;
        x    = (rs == 0) ? 32'd0 : arch_regs[rs];
        y    = (rt == 0) ? 32'd0 : arch_regs[rt];
        simm = {{16{ins[15]}}, ins[15:0]};
        b    = (op == OP_RTYPE) ? y : simm;
        pc4  = arch_pc + 32'd4;
        nxt  = pc4;
        if (c == CMD_WRITE) begin
            arch_mem[addr[DM_AW-1:0]]   = data;
            mem_loaded[addr[DM_AW-1:0]] = 1'b1;
        end else if (c == CMD_READ) begin
            r.read_byte = arch_mem[addr[DM_AW-1:0]];
        end else if (c == CMD_EXEC && !arch_halted) begin
            if (ins == HALT_WORD) begin
                arch_halted = 1'b1;
            end else begin
                if (op == OP_JUMP) begin
                    nxt = {pc4[31:28], ins[25:0], 2'b00};
                end else begin
                    if (op == OP_LW || op == OP_SW) aop = ALU_ADD;
                    else if (op == OP_RTYPE) aop = ins[2:0];
                    else aop = op[2:0];
                    case (aop)
                        ALU_ADD: sum = x + b;
                        ALU_SUB: sum = x - b;
                        ALU_AND: sum = x & b;
                        ALU_OR:  sum = x | b;
                        ALU_NOR: sum = ~(x | b);
                        default: sum = 32'd0;
                    endcase
                    if (op == OP_SW) begin
                        // store big-endian, each byte address wrapping on its own
                        for (k = 0; k < 4; k++) begin
                            loc = sum[DM_AW-1:0] + DM_AW'(k);
                            arch_mem[loc]   = y[31-8*k -: 8];
                            mem_loaded[loc] = 1'b1;
                        end
                    end else if (op == OP_BEQ) begin
                        if (x == y) nxt = pc4 + (simm << 2);
                    end else begin
                        val = sum;
                        if (op == OP_LW) begin
                            for (k = 0; k < 4; k++) begin
                                loc = sum[DM_AW-1:0] + DM_AW'(k);
                                val = {val[23:0], arch_mem[loc]};
                            end
                        end
                        // drop writes to register zero
                        if (dest != 0) begin
                            arch_regs[dest] = val;
                            r.reg_written   = 1'b1;
                            r.reg_index     = dest;
                            r.reg_value     = val;
                        end
                    end
                end
                arch_pc = nxt;
            end
        end
        r.next_pc = arch_pc;
        r.halted  = arch_halted;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Send one word: optional idle burst, predict, then hold until accepted
    task automatic issue_word(t_cmd c, logic [31:0] ins, logic [15:0] addr, logic [7:0] data);
        int gap;
        bit taken;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_retires.push_back(predict_retire(c, ins, addr, data));
        i_valid       <= 1'b1;
        i_cmd         <= c;
        i_instruction <= ins;
        i_mem_address <= addr;
        i_mem_byte    <= data;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stall the result channel in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_retires.size() == 0) begin
                report_mismatch("unexpected result, next_pc", o_next_pc, 32'd0);
            end else begin
                want = pending_retires.pop_front();
                if (o_next_pc !== want.next_pc)
                    report_mismatch("next_pc", o_next_pc, want.next_pc);
                if (o_halted !== want.halted)
                    report_mismatch("halted", 32'(o_halted), 32'(want.halted));
                if (o_reg_written !== want.reg_written)
                    report_mismatch("reg_written", 32'(o_reg_written),
                                    32'(want.reg_written));
                if (o_reg_index !== want.reg_index)
                    report_mismatch("reg_index", 32'(o_reg_index), 32'(want.reg_index));
                if (o_reg_value !== want.reg_value)
                    report_mismatch("reg_value", o_reg_value, want.reg_value);
                if (o_read_byte !== want.read_byte)
                    report_mismatch("read_byte", 32'(o_read_byte), 32'(want.read_byte));
            end
            results_seen++;
        end
    end

    // End the run when no word moves on either channel for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_mips_subset_single_cycle_core failed");
            $finish;
        end
    end

    task automatic test_byte_access();
        issue_word(CMD_WRITE, 32'd0, 16'hFFFF, 8'hFF);
        issue_word(CMD_WRITE, 32'hFFFF_FFFF, 16'h0000, 8'h00);
        issue_word(CMD_READ, 32'd0, 16'hFFFF, 8'h00);
        issue_word(CMD_READ, 32'd0, 16'h0000, 8'hFF);
        issue_word(CMD_NONE, $urandom, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_alu_ops();
        issue_word(CMD_EXEC, enc_i(OP_ADDIU, 5'd0, 5'd1, 16'h7FFF), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h8000), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd2, 5'd3, ALU_ADD), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd0, 5'd1, 5'd4, ALU_SUB), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd2, 5'd5, ALU_AND), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd2, 5'd6, ALU_OR), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd0, 5'd0, 5'd7, ALU_NOR), 16'd0, 8'd0);
        // undefined op still writes back zero
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd2, 5'd8, ALU_UNDEF), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd1, 5'd0, ALU_ADD), 16'd0, 8'd0);
        // other I-type opcodes take the ALU op from the opcode
        issue_word(CMD_EXEC, enc_i(OP_ORI, 5'd0, 5'd9, 16'h8001), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_i(OP_ADDI, 5'd3, 5'd10, 16'h0001), 16'd0, 8'd0);
    endtask

    task automatic test_memory_ops();
        // word straddles the top of memory and wraps to address zero
        issue_word(CMD_EXEC, enc_i(OP_SW, 5'd0, 5'd2, 16'hFFFE), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_i(OP_LW, 5'd0, 5'd11, 16'hFFFE), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_i(OP_LW, 5'd0, 5'd0, 16'hFFFE), 16'd0, 8'd0);
        issue_word(CMD_READ, 32'd0, 16'h0001, 8'd0);
    endtask

    task automatic test_control_flow();
        issue_word(CMD_EXEC, enc_i(OP_BEQ, 5'd1, 5'd1, 16'h8000), 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_i(OP_BEQ, 5'd1, 5'd2, 16'h7FFF), 16'd0, 8'd0);
        issue_word(CMD_EXEC, {OP_JUMP, 26'h3FF_FFFF}, 16'd0, 8'd0);
        issue_word(CMD_EXEC, {OP_JUMP, 26'h000_0000}, 16'd0, 8'd0);
    endtask

    // Mostly well-formed instructions on loaded memory, plus byte traffic and noise
    task automatic test_random_traffic(int count);
        logic [31:0]      ins, x, lw_addr;
        logic [15:0]      tgt;
        logic [4:0]       rs, rt, rd;
        logic [2:0]       aop;
        logic [DM_AW-1:0] loc;
        t_cmd             c;
        int               n, k, pick;
        window_base = 16'($urandom);
        for (n = 0; n < WINDOW_BYTES; n++)
            issue_word(CMD_WRITE, $urandom, window_base + 16'(n), 8'($urandom));
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            rs   = 5'($urandom);
            rt   = 5'($urandom);
            rd   = 5'($urandom);
            x    = (rs == 0) ? 32'd0 : arch_regs[rs];
            ins  = $urandom;
            tgt  = 16'($urandom);
            c    = CMD_EXEC;
            case ($urandom_range(0, 5))
                0: aop = ALU_ADD;
                1: aop = ALU_SUB;
                2: aop = ALU_AND;
                3: aop = ALU_OR;
                4: aop = ALU_NOR;
                default: aop = ALU_UNDEF;
            endcase
            if (pick < 22) begin
                ins = enc_r(rs, rt, rd, aop);
            end else if (pick < 34) begin
                ins = enc_i(OP_ADDIU, rs, rt, 16'($urandom));
            end else if (pick < 46) begin
                if (stored_words.size() > 0 && $urandom_range(0, 1))
                    tgt = stored_words[$urandom_range(0, stored_words.size() - 1)];
                else
                    tgt = window_base + 16'($urandom_range(0, WINDOW_BYTES - 4));
                ins = enc_i(OP_LW, rs, rt, tgt - x[15:0]);
            end else if (pick < 56) begin
                ins = enc_i(OP_SW, rs, rt, tgt - x[15:0]);
                stored_words.push_back(tgt);
            end else if (pick < 63) begin
                ins = enc_i(OP_BEQ, rs, $urandom_range(0, 1) ? rs : rt, 16'($urandom));
            end else if (pick < 67) begin
                ins = {OP_JUMP, 26'($urandom)};
            end else if (pick < 75) begin
                c = CMD_WRITE;
            end else if (pick < 83) begin
                c = CMD_READ;
                if (stored_words.size() > 0 && $urandom_range(0, 1))
                    tgt = stored_words[$urandom_range(0, stored_words.size() - 1)]
                          + 16'($urandom_range(0, 3));
                else
                    tgt = window_base + 16'($urandom_range(0, WINDOW_BYTES - 1));
            end else if (pick > 92) begin
                c = CMD_NONE;
            end
            // keep the halt for the end and never load from unwritten memory
            if (c == CMD_EXEC) begin
                if (ins == HALT_WORD) ins[0] = 1'b0;
                if (ins[31:26] == OP_LW) begin
                    lw_addr = ((ins[25:21] == 0) ? 32'd0 : arch_regs[ins[25:21]])
                              + {{16{ins[15]}}, ins[15:0]};
                    for (k = 0; k < 4; k++) begin
                        loc = lw_addr[DM_AW-1:0] + DM_AW'(k);
                        if (!mem_loaded[loc]) ins[31:26] = OP_ADDIU;
                    end
                end
            end
            issue_word(c, ins, tgt, 8'($urandom));
        end
    endtask

    task automatic test_halt();
        issue_word(CMD_EXEC, HALT_WORD, 16'd0, 8'd0);
        issue_word(CMD_EXEC, enc_r(5'd1, 5'd1, 5'd12, ALU_ADD), 16'd0, 8'd0);
        issue_word(CMD_WRITE, 32'd0, 16'h1234, 8'h5A);
        issue_word(CMD_READ, 32'd0, 16'h1234, 8'd0);
        issue_word(CMD_NONE, $urandom, 16'($urandom), 8'($urandom));
        issue_word(CMD_EXEC, HALT_WORD, 16'd0, 8'd0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;
        test_byte_access();
        test_alu_ops();
        test_memory_ops();
        test_control_flow();
        test_random_traffic(1000);
        // run the tail with both channels wide open
        idle_en = 1'b0;
        test_random_traffic(200);
        test_halt();
        i_valid <= 1'b0;
        while (pending_retires.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_mips_subset_single_cycle_core passed");
        else
            $display("tb_mips_subset_single_cycle_core failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/msc_pkg.sv
rtl/core/msc_rf.sv
rtl/core/msc_dmem.sv
rtl/core/msc_outq.sv
rtl/core/mips_subset_single_cycle_core.sv
test/tb_mips_subset_single_cycle_core.sv
